// File: sv/pidpi_pkg.sv
// Shared types and constants for the PID regulator block.
// No dependencies; imported by every module of the block.
package pidpi_pkg;

  // Fixed field widths of the configuration and result words.
  localparam int GainW        = 16;
  localparam int GainFracBits = 8;
  localparam int SumW         = 32;
  localparam int SumLimitW    = 31;
  localparam int DriveLimitW  = 15;
  localparam int DriveW       = 16;

  // Configuration port geometry.
  localparam int AddrW = 5;
  localparam int DataW = 32;

  // Register indexes, one per 32-bit word.
  typedef enum logic [2:0] {
    RegMode       = 3'd0,
    RegGainP      = 3'd1,
    RegGainI      = 3'd2,
    RegGainD      = 3'd3,
    RegSumLimit   = 3'd4,
    RegDriveLimit = 3'd5
  } reg_idx_e;

  // Controller form.
  typedef enum logic {
    ModePositional  = 1'b0,
    ModeIncremental = 1'b1
  } mode_e;

  // Input word action.
  typedef enum logic {
    ActStep  = 1'b0,
    ActClear = 1'b1
  } action_e;

  localparam logic [DriveLimitW-1:0] DriveLimitReset = '1;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    mode_e                  mode;
    logic [GainW-1:0]       gain_p;
    logic [GainW-1:0]       gain_i;
    logic [GainW-1:0]       gain_d;
    logic [SumLimitW-1:0]   sum_limit;
    logic [DriveLimitW-1:0] drive_limit;
  } cfg_t;

endpackage

// File: sv/pidpi_regs.sv
// Configuration register file with an APB-style slave port.
// Depends on pidpi_pkg for the register map and the cfg_t bundle.
module pidpi_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [pidpi_pkg::AddrW-1:0] paddr,
  input  logic [pidpi_pkg::DataW-1:0] pwdata,
  output logic [pidpi_pkg::DataW-1:0] prdata,
  output logic                    pready,
  output pidpi_pkg::cfg_t         cfg_o
);
  import pidpi_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Register writes complete in the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode        <= ModePositional;
      cfg_q.gain_p      <= '0;
      cfg_q.gain_i      <= '0;
      cfg_q.gain_d      <= '0;
      cfg_q.sum_limit   <= '0;
      cfg_q.drive_limit <= DriveLimitReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegMode:       cfg_q.mode        <= mode_e'(pwdata[0]);
        RegGainP:      cfg_q.gain_p      <= pwdata[GainW-1:0];
        RegGainI:      cfg_q.gain_i      <= pwdata[GainW-1:0];
        RegGainD:      cfg_q.gain_d      <= pwdata[GainW-1:0];
        RegSumLimit:   cfg_q.sum_limit   <= pwdata[SumLimitW-1:0];
        RegDriveLimit: cfg_q.drive_limit <= pwdata[DriveLimitW-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux; unused addresses read as zero.
  always_comb begin
    prdata = '0;
    case (reg_idx)
      RegMode:       prdata = DataW'(cfg_q.mode);
      RegGainP:      prdata = DataW'(cfg_q.gain_p);
      RegGainI:      prdata = DataW'(cfg_q.gain_i);
      RegGainD:      prdata = DataW'(cfg_q.gain_d);
      RegSumLimit:   prdata = DataW'(cfg_q.sum_limit);
      RegDriveLimit: prdata = DataW'(cfg_q.drive_limit);
      default:       prdata = '0;
    endcase
  end

endmodule

// File: sv/pidpi_calc.sv
// One PID control step as combinational logic: error, clamped sum,
// three gain products, shift, drive clamp and next state. Uses pidpi_pkg.
module pidpi_calc #(
  parameter int SAMPLE_BITS = 16
) (
  input  pidpi_pkg::cfg_t                    cfg_i,
  input  pidpi_pkg::action_e                 action_i,
  input  logic signed [SAMPLE_BITS-1:0]      target_i,
  input  logic signed [SAMPLE_BITS-1:0]      measured_i,
  input  logic signed [SAMPLE_BITS:0]        last_err_i,
  input  logic signed [SAMPLE_BITS:0]        prior_err_i,
  input  logic signed [pidpi_pkg::SumW-1:0]  err_sum_i,
  input  logic signed [pidpi_pkg::DriveW-1:0] held_drive_i,
  output logic signed [SAMPLE_BITS:0]        last_err_o,
  output logic signed [SAMPLE_BITS:0]        prior_err_o,
  output logic signed [pidpi_pkg::SumW-1:0]  err_sum_o,
  output logic signed [pidpi_pkg::DriveW-1:0] drive_o,
  output logic                               saturated_o
);
  import pidpi_pkg::*;

  localparam int ErrW     = SAMPLE_BITS + 1;
  localparam int SumCalcW = ((ErrW > SumW) ? ErrW : SumW) + 1;
  localparam int OpW      = ((SAMPLE_BITS + 3) > SumW) ? (SAMPLE_BITS + 3) : SumW;
  localparam int ProdW    = GainW + OpW;
  localparam int AccW     = ProdW + 2;
  localparam int RawW     = AccW + 1;

  logic signed [ErrW-1:0]     err;
  logic signed [OpW-1:0]      err_diff;
  logic signed [OpW-1:0]      err_diff2;
  logic signed [SumCalcW-1:0] sum_wide;
  logic signed [SumCalcW-1:0] sum_lim;
  logic signed [SumW-1:0]     sum_clamped;
  logic signed [OpW-1:0]      op_p;
  logic signed [OpW-1:0]      op_i;
  logic signed [OpW-1:0]      op_d;
  logic signed [ProdW-1:0]    prod_p;
  logic signed [ProdW-1:0]    prod_i;
  logic signed [ProdW-1:0]    prod_d;
  logic signed [AccW-1:0]     acc;
  logic signed [AccW-1:0]     acc_shr;
  logic signed [RawW-1:0]     raw;
  logic signed [RawW-1:0]     drive_lim;
  logic signed [RawW-1:0]     drive_sat;
  logic                       hit;
  logic                       incr;

  assign incr = (cfg_i.mode == ModeIncremental);

  // Error and its first and second differences.
  assign err       = ErrW'(target_i) - ErrW'(measured_i);
  assign err_diff  = OpW'(err) - OpW'(last_err_i);
  assign err_diff2 = OpW'(err) - (OpW'(last_err_i) <<< 1) + OpW'(prior_err_i);

  // Running error sum, clamped to the sum limit.
  assign sum_wide = SumCalcW'(err_sum_i) + SumCalcW'(err);
  assign sum_lim  = SumCalcW'($signed({1'b0, cfg_i.sum_limit}));
  always_comb begin
    if (sum_wide > sum_lim) begin
      sum_clamped = SumW'(sum_lim);
    end else if (sum_wide < -sum_lim) begin
      sum_clamped = SumW'(-sum_lim);
    end else begin
      sum_clamped = SumW'(sum_wide);
    end
  end

  // The two forms share the three multipliers with swapped operands.
  assign op_p = incr ? err_diff  : OpW'(err);
  assign op_i = incr ? OpW'(err) : OpW'(sum_clamped);
  assign op_d = incr ? err_diff2 : err_diff;

  assign prod_p = ProdW'($signed(cfg_i.gain_p)) * ProdW'(op_p);
  assign prod_i = ProdW'($signed(cfg_i.gain_i)) * ProdW'(op_i);
  assign prod_d = ProdW'($signed(cfg_i.gain_d)) * ProdW'(op_d);

  // Exact sum, then floor shift out of the gain fraction.
  assign acc     = AccW'(prod_p) + AccW'(prod_i) + AccW'(prod_d);
  assign acc_shr = acc >>> GainFracBits;
  assign raw     = incr ? (RawW'(held_drive_i) + RawW'(acc_shr)) : RawW'(acc_shr);

  // Drive clamp; saturation flags a value strictly outside the limit.
  assign drive_lim = RawW'($signed({1'b0, cfg_i.drive_limit}));
  always_comb begin
    hit       = 1'b0;
    drive_sat = raw;
    if (raw > drive_lim) begin
      hit       = 1'b1;
      drive_sat = drive_lim;
    end else if (raw < -drive_lim) begin
      hit       = 1'b1;
      drive_sat = -drive_lim;
    end
  end

  // Result and next state; a clear zeroes everything.
  always_comb begin
    if (action_i == ActClear) begin
      drive_o     = '0;
      saturated_o = 1'b0;
      last_err_o  = '0;
      prior_err_o = '0;
      err_sum_o   = '0;
    end else begin
      drive_o     = DriveW'(drive_sat);
      saturated_o = hit;
      last_err_o  = err;
      prior_err_o = incr ? last_err_i : prior_err_i;
      err_sum_o   = incr ? err_sum_i : sum_clamped;
    end
  end

endmodule

// File: sv/pid_controller_pos_inc.sv
// Top level of the PID regulator: input register, step datapath, state
// and output register. Depends on pidpi_pkg, pidpi_regs and pidpi_calc.

// One input word gives one result word on the result port: an accepted word
// is held in the input register, which feeds the combinational step logic
// (three gain multipliers, an adder and two clamps), whose result is written
// to the output register together with the controller state at the same edge.
// A new word can be accepted in every cycle unless in_stall_o is raised.
// The error history, the error sum and the held drive value are updated with
// each result, so consecutive words see each other's state without gaps. A
// word with action set clears all state and returns a drive of zero.
// Registers are meant to be written only while no word is in flight.
module pid_controller_pos_inc #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                action_i,
  input  logic signed [SAMPLE_BITS-1:0]       target_i,
  input  logic signed [SAMPLE_BITS-1:0]       measured_i,
  // Result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pidpi_pkg::DriveW-1:0] drive_o,
  output logic                                saturated_o,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pidpi_pkg::AddrW-1:0]         paddr,
  input  logic [pidpi_pkg::DataW-1:0]         pwdata,
  output logic [pidpi_pkg::DataW-1:0]         prdata,
  output logic                                pready
);
  import pidpi_pkg::*;

  localparam int ErrW = SAMPLE_BITS + 1;

  cfg_t cfg;

  // Input register
  logic                          s1_valid_q;
  logic                          s1_valid_d;
  action_e                       s1_action_q;
  logic signed [SAMPLE_BITS-1:0] s1_target_q;
  logic signed [SAMPLE_BITS-1:0] s1_measured_q;

  // Controller state
  logic signed [ErrW-1:0]   last_err_q;
  logic signed [ErrW-1:0]   last_err_d;
  logic signed [ErrW-1:0]   prior_err_q;
  logic signed [ErrW-1:0]   prior_err_d;
  logic signed [SumW-1:0]   err_sum_q;
  logic signed [SumW-1:0]   err_sum_d;
  logic signed [DriveW-1:0] held_drive_q;

  // Output register
  logic                     out_valid_q;
  logic                     out_valid_d;
  logic signed [DriveW-1:0] drive_q;
  logic signed [DriveW-1:0] drive_d;
  logic                     sat_q;
  logic                     sat_d;

  logic in_accept;
  logic s1_advance;
  logic out_blocked;

  pidpi_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pidpi_calc #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_calc (
    .cfg_i        (cfg),
    .action_i     (s1_action_q),
    .target_i     (s1_target_q),
    .measured_i   (s1_measured_q),
    .last_err_i   (last_err_q),
    .prior_err_i  (prior_err_q),
    .err_sum_i    (err_sum_q),
    .held_drive_i (held_drive_q),
    .last_err_o   (last_err_d),
    .prior_err_o  (prior_err_d),
    .err_sum_o    (err_sum_d),
    .drive_o      (drive_d),
    .saturated_o  (sat_d)
  );

  // Handshake: the input register moves on unless a result word is stuck.
  assign out_blocked = out_valid_q && out_stall_i;
  assign s1_advance  = s1_valid_q && !out_blocked;
  assign in_stall_o  = s1_valid_q && out_blocked;
  assign in_accept   = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !s1_advance);
  assign out_valid_d = s1_advance || out_blocked;

  // Control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input word capture
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q   <= action_e'(action_i);
      s1_target_q   <= target_i;
      s1_measured_q <= measured_i;
    end
  end

  // Controller state advances with each step that reaches the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q   <= '0;
      prior_err_q  <= '0;
      err_sum_q    <= '0;
      held_drive_q <= '0;
    end else if (s1_advance) begin
      last_err_q   <= last_err_d;
      prior_err_q  <= prior_err_d;
      err_sum_q    <= err_sum_d;
      held_drive_q <= drive_d;
    end
  end

  // Result word register
  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      drive_q <= drive_d;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign saturated_o = sat_q;

endmodule
